// File: design/bsirq_pkg.sv
// Shared types and constants for the bank switch mapper with scanline interrupt.
package bsirq_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_e;

  localparam logic [15:0] PrgAddrLo = 16'h8000;
  localparam logic [15:0] PrgAddrHi = 16'h8002;
  localparam logic [15:0] ChrAddrLo = 16'hA000;
  localparam logic [15:0] ChrAddrHi = 16'hA007;
  localparam logic [15:0] IrqAddrLo = 16'hC001;
  localparam logic [15:0] IrqAddrHi = 16'hC003;
  localparam logic [15:0] EnAddr    = 16'hE000;

  localparam logic       CmdWrite = 1'b0;
  localparam logic       CmdTick  = 1'b1;

  localparam logic       CfgPrgBanks = 1'b0;
  localparam logic       CfgChrBanks = 1'b1;

  localparam logic [7:0] BankCountReset = 8'd16;
  localparam logic [7:0] PrgPage2Reset  = 8'd30;

  localparam int unsigned ModBits  = 12;
  localparam int unsigned DataBits = 8;

endpackage

// File: design/bank_switch_scanline_irq.sv
// Bank switch mapper with scanline interrupt: top level with bit-serial modulo unit.
// A program or pattern page write runs from acceptance through 8 restoring steps of the
// shared subtract/compare unit, one per data bit, then the hand-off to the output
// register; any other transaction goes straight to the hand-off.
// Transactions run one at a time; a result still waiting in the output
// register holds the next one in its hand-off state, which blocks input meanwhile.
// Reset (async, active low): pages 0,1,30 and 0..7, bank counts 16, interrupt disarmed,
// target line 0, master enable on.
module bank_switch_scanline_irq (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic [8:0]  scanline_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  prg_bank_a_o,
  output logic [7:0]  prg_bank_b_o,
  output logic [7:0]  prg_bank_c_o,
  output logic [7:0]  chr_bank_0_o,
  output logic [7:0]  chr_bank_1_o,
  output logic [7:0]  chr_bank_2_o,
  output logic [7:0]  chr_bank_3_o,
  output logic [7:0]  chr_bank_4_o,
  output logic [7:0]  chr_bank_5_o,
  output logic [7:0]  chr_bank_6_o,
  output logic [7:0]  chr_bank_7_o,
  output logic        irq_pulse_o
);

  bsirq_pkg::state_e state_q, state_d;

  logic [7:0] prg_banks_q;
  logic [7:0] chr_banks_q;
  logic [7:0] prg_q [3];
  logic [7:0] chr_q [8];
  logic [7:0] line_q;
  logic       armed_q;
  logic       enable_q;
  logic       pulse_q;

  // modulo unit
  logic [bsirq_pkg::ModBits-1:0]  rem_q;
  logic [bsirq_pkg::ModBits-1:0]  mod_q;
  logic [bsirq_pkg::DataBits-1:0] dvd_q;
  logic [2:0]                     cnt_q;
  logic                           dst_chr_q;
  logic [2:0]                     dst_idx_q;
  logic [bsirq_pkg::ModBits-1:0]  trial;
  logic [bsirq_pkg::ModBits-1:0]  rem_next;

  // output register
  logic       out_valid_q;
  logic [7:0] out_prg_q [3];
  logic [7:0] out_chr_q [8];
  logic       out_pulse_q;

  logic in_fire;
  logic is_prg, is_chr, is_irq, is_en;
  logic [bsirq_pkg::ModBits-1:0] prg_mod, chr_mod;
  logic start_calc;
  logic last_step;
  logic load_out;
  logic tick_hit;

  assign in_ready_o = (state_q == bsirq_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_prg = (addr_i >= bsirq_pkg::PrgAddrLo) && (addr_i <= bsirq_pkg::PrgAddrHi);
  assign is_chr = (addr_i >= bsirq_pkg::ChrAddrLo) && (addr_i <= bsirq_pkg::ChrAddrHi);
  assign is_irq = (addr_i >= bsirq_pkg::IrqAddrLo) && (addr_i <= bsirq_pkg::IrqAddrHi);
  assign is_en  = (addr_i == bsirq_pkg::EnAddr);

  assign prg_mod = {3'b000, prg_banks_q, 1'b0};
  assign chr_mod = {1'b0, chr_banks_q, 3'b000};

  // zero modulus means the page write is dropped
  assign start_calc = (cmd_i == bsirq_pkg::CmdWrite) &&
                      ((is_prg && (prg_banks_q != 8'd0)) ||
                       (is_chr && (chr_banks_q != 8'd0)));

  assign tick_hit = armed_q && enable_q && (scanline_i == {1'b0, line_q});

  // one restoring-division step: shift in next dividend bit, subtract if it fits
  assign trial    = {rem_q[bsirq_pkg::ModBits-2:0], dvd_q[bsirq_pkg::DataBits-1]};
  assign rem_next = (trial >= mod_q) ? (trial - mod_q) : trial;
  assign last_step = (cnt_q == 3'd7);

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      bsirq_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = start_calc ? bsirq_pkg::ST_CALC : bsirq_pkg::ST_DONE;
        end
      end
      bsirq_pkg::ST_CALC: begin
        if (last_step) begin
          state_d = bsirq_pkg::ST_DONE;
        end
      end
      bsirq_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = bsirq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bsirq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsirq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration and mapper state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_banks_q <= bsirq_pkg::BankCountReset;
      chr_banks_q <= bsirq_pkg::BankCountReset;
      prg_q[0]    <= 8'd0;
      prg_q[1]    <= 8'd1;
      prg_q[2]    <= bsirq_pkg::PrgPage2Reset;
      for (int i = 0; i < 8; i++) begin
        chr_q[i] <= 8'(i);
      end
      line_q      <= 8'd0;
      armed_q     <= 1'b0;
      enable_q    <= 1'b1;
      pulse_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bsirq_pkg::CfgPrgBanks) begin
          prg_banks_q <= cfg_data_i;
        end else begin
          chr_banks_q <= cfg_data_i;
        end
      end
      if (in_fire) begin
        pulse_q <= 1'b0;
        if (cmd_i == bsirq_pkg::CmdTick) begin
          if (tick_hit) begin
            armed_q <= 1'b0;
            pulse_q <= 1'b1;
          end
        end else if (is_irq) begin
          line_q  <= data_i;
          armed_q <= (data_i != 8'd0);
        end else if (is_en) begin
          enable_q <= data_i[0];
        end
      end
      if ((state_q == bsirq_pkg::ST_CALC) && last_step) begin
        if (dst_chr_q) begin
          chr_q[dst_idx_q] <= rem_next[7:0];
        end else begin
          prg_q[dst_idx_q[1:0]] <= rem_next[7:0];
        end
      end
    end
  end

  // modulo unit control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (in_fire) begin
      cnt_q <= 3'd0;
    end else if (state_q == bsirq_pkg::ST_CALC) begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rem_q     <= '0;
      dvd_q     <= data_i;
      dst_chr_q <= is_chr;
      dst_idx_q <= addr_i[2:0];
      mod_q     <= is_chr ? chr_mod : prg_mod;
    end else if (state_q == bsirq_pkg::ST_CALC) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[bsirq_pkg::DataBits-2:0], 1'b0};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_prg_q   <= prg_q;
      out_chr_q   <= chr_q;
      out_pulse_q <= pulse_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign prg_bank_a_o = out_prg_q[0];
  assign prg_bank_b_o = out_prg_q[1];
  assign prg_bank_c_o = out_prg_q[2];
  assign chr_bank_0_o = out_chr_q[0];
  assign chr_bank_1_o = out_chr_q[1];
  assign chr_bank_2_o = out_chr_q[2];
  assign chr_bank_3_o = out_chr_q[3];
  assign chr_bank_4_o = out_chr_q[4];
  assign chr_bank_5_o = out_chr_q[5];
  assign chr_bank_6_o = out_chr_q[6];
  assign chr_bank_7_o = out_chr_q[7];
  assign irq_pulse_o  = out_pulse_q;

endmodule
